// ----- hw/rtl/planar_squared_distance_transform_core_defines.svh -----
// Assertion macros for the squared distance transform core checker.
// Depends on nothing; used by the checker file only.
`ifndef PLANAR_SQUARED_DISTANCE_TRANSFORM_CORE_DEFINES_SVH
`define PLANAR_SQUARED_DISTANCE_TRANSFORM_CORE_DEFINES_SVH

`define PDT_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("pdt check failed");

`define PDT_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("pdt check failed");

`endif

// ----- hw/rtl/pdt_pkg.sv -----
// Shared types and constants of the squared distance transform core.
// No dependencies.
package pdt_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int PIX_AW     = $clog2(PIX_DEPTH);
	localparam int CNT_W      = PIX_AW + 1;
	localparam int DIM_W      = 9;
	localparam int COL_DEPTH  = MAX_HEIGHT + 2;
	localparam int BND_DEPTH  = MAX_HEIGHT + 3;
	localparam int CRD_W      = $clog2(BND_DEPTH);
	localparam int CV_W       = 9;
	localparam int SQ_W       = 18;
	localparam int NUM_W      = SQ_W + 1;
	localparam int DEN_W      = CRD_W + 1;
	localparam int FRAC_W     = 16;
	localparam int QUO_W      = NUM_W - 1 + FRAC_W;
	localparam int S_W        = QUO_W + 2;
	localparam int DIST_W     = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [DIST_W-1:0] DIST_SAT = 16'd65534;
	localparam logic [DIST_W-1:0] MASK_FG  = 16'hFFFF;

	typedef struct packed {
		logic       func;
		logic [7:0] mask_value;
	} cmd_t;

	typedef struct packed {
		logic [DIST_W-1:0] squared_distance;
		logic              last_of_plane;
	} res_t;

	typedef enum logic [19:0] {
		ST_LOAD   = 20'h00001,
		ST_READ   = 20'h00002,
		ST_RF_RD  = 20'h00004,
		ST_RF_WR  = 20'h00008,
		ST_RB_RD  = 20'h00010,
		ST_RB_WR  = 20'h00020,
		ST_CP_RD  = 20'h00040,
		ST_CP_WR  = 20'h00080,
		ST_EN_Q   = 20'h00100,
		ST_EN_QW  = 20'h00200,
		ST_EN_V   = 20'h00400,
		ST_EN_VW  = 20'h00800,
		ST_EN_DIV = 20'h01000,
		ST_EN_DW  = 20'h02000,
		ST_EN_CMP = 20'h04000,
		ST_EN_KW  = 20'h08000,
		ST_SC_Q   = 20'h10000,
		ST_SC_QW  = 20'h20000,
		ST_SC_V   = 20'h40000,
		ST_SC_VW  = 20'h80000
	} state_t;

endpackage

// ----- hw/rtl/planar_squared_distance_transform_core.sv -----
// A load writes one pixel; a read result shows in the cycle after its command.
// The final load of a plane starts the transform: a forward and a backward pass per row,
// then per column a copy into the column buffer, envelope tests that each use the 34-step
// shared divider (about 2H tests), a scan of each pixel and an envelope step for each
// boundary passed in the scan. Results cannot be stalled.
// Reset clears control state and sizes to 256 x 256; memories need no clearing.
module planar_squared_distance_transform_core
	import pdt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 result_valid,
	output res_t                 result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	state_t state_q;
	logic [DIM_W-1:0] w_q, h_q, w_eff, h_eff;
	logic [CNT_W-1:0] total, load_cnt_q, read_cnt_q, row_base_q, cp_addr_q, row_addr;
	logic [DIM_W-1:0] x_q, y_q, lz_q, nz_q, col_q;
	logic [CRD_W-1:0] q_q, k_q, top_q, v_q, h_p1;
	logic signed [S_W-1:0]   bk_q, s_q, div_quo;
	logic signed [NUM_W-1:0] num_q;
	logic [SQ_W-1:0]  hq_q, gv, df;
	logic [DIM_W-1:0] fdist, rdist, adx;
	logic res_valid_q, last_q, accept, pop, div_done;

	logic              pl_we;
	logic [PIX_AW-1:0] pl_waddr, pl_raddr;
	logic [DIST_W-1:0] pl_wdata, pl_rdata;
	logic              cv_we;
	logic [CRD_W-1:0]  cv_raddr;
	logic [CV_W-1:0]   cv_wdata, cv_rdata;
	logic              pos_we;
	logic [CRD_W-1:0]  pos_waddr, pos_raddr, pos_wdata, pos_rdata;
	logic [CRD_W-1:0]  bnd_raddr;
	logic [S_W-1:0]    bnd_rdata;

	assign w_eff = (w_q == '0) ? DIM_W'(1) : ((w_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_q);
	assign h_eff = (h_q == '0) ? DIM_W'(1) : ((h_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_q);
	assign total = CNT_W'({{(CNT_W-DIM_W){1'b0}}, w_eff} * {{(CNT_W-DIM_W){1'b0}}, h_eff});
	assign h_p1  = CRD_W'(h_eff) + CRD_W'(1);

	assign busy     = !(state_q == ST_LOAD || state_q == ST_READ);
	assign accept   = start && !busy;
	assign row_addr = row_base_q + CNT_W'(x_q);
	assign fdist    = x_q + DIM_W'(1) - lz_q;
	assign rdist    = nz_q - x_q;
	assign pop      = (k_q != '0) && (s_q <= bk_q);
	assign gv       = SQ_W'({9'b0, cv_rdata} * {9'b0, cv_rdata}) + SQ_W'({9'b0, v_q} * {9'b0, v_q});
	assign adx      = (q_q >= v_q) ? (q_q - v_q) : (v_q - q_q);
	assign df       = SQ_W'({9'b0, adx} * {9'b0, adx}) + SQ_W'({9'b0, cv_rdata} * {9'b0, cv_rdata});

	always_comb begin
		pl_we     = 1'b0;
		pl_waddr  = cp_addr_q[PIX_AW-1:0];
		pl_wdata  = '0;
		pl_raddr  = read_cnt_q[PIX_AW-1:0];
		cv_we     = 1'b0;
		cv_wdata  = '0;
		cv_raddr  = q_q;
		pos_we    = 1'b0;
		pos_waddr = k_q + CRD_W'(1);
		pos_wdata = q_q;
		pos_raddr = k_q;
		bnd_raddr = k_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && cmd.func == FUNC_LOAD) begin
					pl_we    = 1'b1;
					pl_waddr = load_cnt_q[PIX_AW-1:0];
					pl_wdata = (cmd.mask_value != '0) ? MASK_FG : '0;
				end
			end
			ST_RF_RD, ST_RB_RD: pl_raddr = row_addr[PIX_AW-1:0];
			ST_RF_WR: begin
				pl_we    = (pl_rdata != '0);
				pl_waddr = row_addr[PIX_AW-1:0];
				pl_wdata = DIST_W'(fdist);
			end
			ST_RB_WR: begin
				pl_we    = (pl_rdata != '0) && (DIST_W'(rdist) < pl_rdata);
				pl_waddr = row_addr[PIX_AW-1:0];
				pl_wdata = DIST_W'(rdist);
			end
			ST_CP_RD: pl_raddr = cp_addr_q[PIX_AW-1:0];
			ST_CP_WR: begin
				cv_we    = 1'b1;
				cv_wdata = (q_q == '0 || q_q == h_p1) ? '0 : pl_rdata[CV_W-1:0];
				if (q_q == h_p1) begin
					pos_we    = 1'b1;
					pos_waddr = '0;
					pos_wdata = '0;
				end
			end
			ST_EN_V, ST_SC_V: cv_raddr = v_q;
			ST_EN_CMP: begin
				pos_raddr = k_q - CRD_W'(1);
				bnd_raddr = k_q - CRD_W'(1);
				pos_we    = !pop;
			end
			ST_SC_Q: bnd_raddr = k_q + CRD_W'(1);
			ST_SC_QW: pl_we = (cv_rdata == '0);
			ST_SC_VW: begin
				pl_we    = 1'b1;
				pl_wdata = (df > SQ_W'(16'hFFFF)) ? DIST_SAT : df[DIST_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			w_q         <= DIM_W'(MAX_WIDTH);
			h_q         <= DIM_W'(MAX_HEIGHT);
			load_cnt_q  <= '0;
			read_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)) begin
				if (cfg_index == CFG_WIDTH) begin
					w_q <= cfg_data;
				end else begin
					h_q <= cfg_data;
				end
				load_cnt_q <= '0;
				read_cnt_q <= '0;
				state_q    <= ST_LOAD;
			end else begin
				case (state_q)
					ST_LOAD: begin
						if (accept && cmd.func == FUNC_LOAD) begin
							load_cnt_q <= load_cnt_q + CNT_W'(1);
							if (load_cnt_q + CNT_W'(1) >= total) begin
								state_q <= ST_RF_RD;
							end
						end
					end
					ST_READ: begin
						if (accept && cmd.func == FUNC_READ) begin
							res_valid_q <= 1'b1;
							if (read_cnt_q + CNT_W'(1) >= total) begin
								state_q    <= ST_LOAD;
								load_cnt_q <= '0;
								read_cnt_q <= '0;
							end else begin
								read_cnt_q <= read_cnt_q + CNT_W'(1);
							end
						end
					end
					ST_RF_RD:  state_q <= ST_RF_WR;
					ST_RF_WR:  state_q <= (x_q == w_eff - DIM_W'(1)) ? ST_RB_RD : ST_RF_RD;
					ST_RB_RD:  state_q <= ST_RB_WR;
					ST_RB_WR: begin
						if (x_q != '0) begin
							state_q <= ST_RB_RD;
						end else if (y_q == h_eff - DIM_W'(1)) begin
							state_q <= ST_CP_RD;
						end else begin
							state_q <= ST_RF_RD;
						end
					end
					ST_CP_RD:  state_q <= ST_CP_WR;
					ST_CP_WR:  state_q <= (q_q == h_p1) ? ST_EN_Q : ST_CP_RD;
					ST_EN_Q:   state_q <= ST_EN_QW;
					ST_EN_QW:  state_q <= ST_EN_V;
					ST_EN_V:   state_q <= ST_EN_VW;
					ST_EN_VW:  state_q <= ST_EN_DIV;
					ST_EN_DIV: state_q <= ST_EN_DW;
					ST_EN_DW:  state_q <= div_done ? ST_EN_CMP : ST_EN_DW;
					ST_EN_CMP: begin
						if (pop) begin
							state_q <= ST_EN_KW;
						end else begin
							state_q <= (q_q == h_p1) ? ST_SC_Q : ST_EN_Q;
						end
					end
					ST_EN_KW:  state_q <= ST_EN_V;
					ST_SC_Q:   state_q <= ST_SC_QW;
					ST_SC_QW: begin
						if (cv_rdata == '0) begin
							if (q_q != CRD_W'(h_eff)) begin
								state_q <= ST_SC_Q;
							end else if (col_q == w_eff - DIM_W'(1)) begin
								state_q    <= ST_READ;
								read_cnt_q <= '0;
								load_cnt_q <= '0;
							end else begin
								state_q <= ST_CP_RD;
							end
						end else if (k_q < top_q && $signed(bnd_rdata) <
								$signed({{(S_W-CRD_W-FRAC_W){1'b0}}, q_q, {FRAC_W{1'b0}}})) begin
							state_q <= ST_SC_Q;
						end else begin
							state_q <= ST_SC_V;
						end
					end
					ST_SC_V:   state_q <= ST_SC_VW;
					ST_SC_VW: begin
						if (q_q != CRD_W'(h_eff)) begin
							state_q <= ST_SC_Q;
						end else if (col_q == w_eff - DIM_W'(1)) begin
							state_q    <= ST_READ;
							read_cnt_q <= '0;
							load_cnt_q <= '0;
						end else begin
							state_q <= ST_CP_RD;
						end
					end
					default: state_q <= ST_LOAD;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				y_q        <= '0;
				x_q        <= '0;
				lz_q       <= '0;
				row_base_q <= '0;
			end
			ST_READ: last_q <= (read_cnt_q == total - CNT_W'(1));
			ST_RF_WR: begin
				if (pl_rdata == '0) begin
					lz_q <= x_q + DIM_W'(1);
				end
				if (x_q == w_eff - DIM_W'(1)) begin
					nz_q <= w_eff;
				end else begin
					x_q <= x_q + DIM_W'(1);
				end
			end
			ST_RB_WR: begin
				if (pl_rdata == '0) begin
					nz_q <= x_q;
				end
				if (x_q != '0) begin
					x_q <= x_q - DIM_W'(1);
				end else begin
					y_q        <= y_q + DIM_W'(1);
					row_base_q <= row_base_q + CNT_W'(w_eff);
					lz_q       <= '0;
					col_q      <= '0;
					q_q        <= '0;
					cp_addr_q  <= '0;
				end
			end
			ST_CP_WR: begin
				if (q_q != '0) begin
					cp_addr_q <= cp_addr_q + CNT_W'(w_eff);
				end
				if (q_q == h_p1) begin
					k_q <= '0;
					q_q <= CRD_W'(1);
				end else begin
					q_q <= q_q + CRD_W'(1);
				end
			end
			ST_EN_QW: begin
				hq_q <= SQ_W'({9'b0, cv_rdata} * {9'b0, cv_rdata}) + SQ_W'({9'b0, q_q} * {9'b0, q_q});
				v_q  <= pos_rdata;
				bk_q <= $signed(bnd_rdata);
			end
			ST_EN_VW: num_q <= $signed({1'b0, hq_q}) - $signed({1'b0, gv});
			ST_EN_DW: begin
				if (div_done) begin
					s_q <= div_quo;
				end
			end
			ST_EN_CMP: begin
				if (pop) begin
					k_q <= k_q - CRD_W'(1);
				end else if (q_q == h_p1) begin
					top_q     <= k_q + CRD_W'(1);
					k_q       <= '0;
					q_q       <= CRD_W'(1);
					cp_addr_q <= CNT_W'(col_q);
				end else begin
					k_q <= k_q + CRD_W'(1);
					q_q <= q_q + CRD_W'(1);
				end
			end
			ST_EN_KW: begin
				v_q  <= pos_rdata;
				bk_q <= $signed(bnd_rdata);
			end
			ST_SC_QW: begin
				if (cv_rdata == '0) begin
					cp_addr_q <= cp_addr_q + CNT_W'(w_eff);
					q_q       <= q_q + CRD_W'(1);
					if (q_q == CRD_W'(h_eff)) begin
						col_q     <= col_q + DIM_W'(1);
						q_q       <= '0;
						cp_addr_q <= CNT_W'(col_q) + CNT_W'(1);
					end
				end else if (k_q < top_q && $signed(bnd_rdata) <
						$signed({{(S_W-CRD_W-FRAC_W){1'b0}}, q_q, {FRAC_W{1'b0}}})) begin
					k_q <= k_q + CRD_W'(1);
				end else begin
					v_q <= pos_rdata;
				end
			end
			ST_SC_VW: begin
				cp_addr_q <= cp_addr_q + CNT_W'(w_eff);
				q_q       <= q_q + CRD_W'(1);
				if (q_q == CRD_W'(h_eff)) begin
					col_q     <= col_q + DIM_W'(1);
					q_q       <= '0;
					cp_addr_q <= CNT_W'(col_q) + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	pdt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_EN_DIV),
		.num    (num_q),
		.den    ({q_q - v_q, 1'b0}),
		.done   (div_done),
		.quo    (div_quo)
	);

	pdt_ram #(.WIDTH(DIST_W), .DEPTH(PIX_DEPTH)) u_plane (
		.clk   (clk),
		.we    (pl_we),
		.waddr (pl_waddr),
		.wdata (pl_wdata),
		.raddr (pl_raddr),
		.rdata (pl_rdata)
	);

	pdt_ram #(.WIDTH(CV_W), .DEPTH(COL_DEPTH)) u_col (
		.clk   (clk),
		.we    (cv_we),
		.waddr (q_q),
		.wdata (cv_wdata),
		.raddr (cv_raddr),
		.rdata (cv_rdata)
	);

	pdt_ram #(.WIDTH(CRD_W), .DEPTH(COL_DEPTH)) u_pos (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	pdt_ram #(.WIDTH(S_W), .DEPTH(BND_DEPTH)) u_bnd (
		.clk   (clk),
		.we    (pos_we && state_q == ST_EN_CMP),
		.waddr (k_q + CRD_W'(1)),
		.wdata (s_q),
		.raddr (bnd_raddr),
		.rdata (bnd_rdata)
	);

	assign result_valid            = res_valid_q;
	assign result.squared_distance = pl_rdata;
	assign result.last_of_plane    = last_q;

endmodule

// ----- hw/rtl/pdt_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pdt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/pdt_div.sv -----
// Shared bit-serial divider: floor(num * 2^16 / den), one quotient bit a cycle.
// Depends on pdt_pkg.
module pdt_div
	import pdt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [S_W-1:0]   quo
);

	localparam int CNT_DW = $clog2(QUO_W + 1);

	logic [DEN_W-1:0]  rem_q;
	logic [QUO_W-1:0]  dvd_q;
	logic [CNT_DW-1:0] cnt_q;
	logic              run_q;
	logic              neg_q;
	logic              done_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W+1:0]  diff;
	logic [NUM_W-2:0]  mag;
	logic [S_W-1:0]    qext;

	assign mag     = num[NUM_W-1] ? (NUM_W-1)'(-num) : num[NUM_W-2:0];
	assign shifted = {rem_q, dvd_q[QUO_W-1]};
	assign diff    = {1'b0, shifted} - {2'b0, den};
	assign qext    = {2'b0, dvd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_DW'(QUO_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_DW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= {mag, {FRAC_W{1'b0}}};
			neg_q <= num[NUM_W-1];
		end else if (run_q) begin
			rem_q <= diff[DEN_W+1] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], ~diff[DEN_W+1]};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? $signed(-qext - {{(S_W-1){1'b0}}, (rem_q != '0)}) : $signed(qext);

endmodule

// ----- hw/rtl/pdt_checker.sv -----
// Port-level checker for the squared distance transform core, bound to the top level.
// Depends on pdt_pkg and the core's defines header.
`include "planar_squared_distance_transform_core_defines.svh"

module pdt_checker
	import pdt_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input cmd_t                 cmd,
	input logic                 result_valid,
	input res_t                 result,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [DIM_W-1:0]     cfg_data
);

	`PDT_ASSERT_SAME(a_beat_follows_read, result_valid, $past(start && !busy && cmd.func == FUNC_READ))
	`PDT_ASSERT_SAME(a_beat_while_idle, result_valid, !busy)
	`PDT_ASSERT_SAME(a_beat_saturated, result_valid, result.squared_distance != 16'hFFFF)
	`PDT_ASSERT_NEXT(a_cfg_drops_plane, cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT), !busy)

endmodule

bind planar_squared_distance_transform_core pdt_checker u_pdt_checker (.*);
